// ===== src/lhp_pkg.sv =====
// Package for the latency histogram percentile block.
// Holds request codes, state encodings and the item type passed from front to back.
// No dependencies.
package lhp_pkg;

   localparam int MS_PER_SECOND = 1000;
   localparam int MS_W          = 32;
   localparam int RATE_W        = 20;
   localparam int DIVD_W        = 42;
   localparam int STEP_W        = 6;
   localparam int PCT_W         = 21;
   localparam int PCT_MAX       = 1048575;
   localparam int BINW_W        = 10;

   typedef enum logic [1:0] {
      REQ_PUT        = 2'd0,
      REQ_CHECKPOINT = 2'd1,
      REQ_REPORT     = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV_MS,
      FR_DIV_BIN,
      FR_ENQ
   } front_state_type;

   typedef enum logic [3:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PUT_RD,
      BK_PUT_WR,
      BK_SUM,
      BK_SCAN,
      BK_CALC,
      BK_FOLD,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      req_kind_type    kind;
      logic [MS_W-1:0] ms;
   } item_type;

endpackage

// ===== src/lhp_front.sv =====
// Front end: accepts requests, converts ticks to milliseconds and a bin index.
// Uses a restoring divider, one quotient bit per cycle, and a reciprocal multiplication
// for the bin. Depends on lhp_pkg.
module lhp_front #(
   parameter int BIN_COUNT    = 1024,
   parameter int BIN_WIDTH_MS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [31:0]                   latency_ticks,
   input  logic [lhp_pkg::RATE_W-1:0]    rate,
   output logic                          enq,
   input  logic                          enq_full,
   output lhp_pkg::item_type             enq_item,
   output logic [$clog2(BIN_COUNT)-1:0]  enq_bin
);
   import lhp_pkg::*;

   localparam int IDX_W  = $clog2(BIN_COUNT);
   localparam int XW     = $clog2(BIN_COUNT * BIN_WIDTH_MS);
   localparam int KS     = XW + $clog2(BIN_WIDTH_MS) + 1;
   localparam int PW     = XW + KS + 1;
   localparam logic [PW-1:0] RECIP =
      PW'(((64'd1 << KS) + 64'(BIN_WIDTH_MS - 1)) / 64'(BIN_WIDTH_MS));
   localparam int TOP_MS = (BIN_COUNT - 1) * BIN_WIDTH_MS;

   front_state_type     state_ff, state_in;
   req_kind_type        kind_ff, kind_in;
   logic [DIVD_W-1:0]   dvd_ff, dvd_in;
   logic [RATE_W-1:0]   rem_ff, rem_in;
   logic [RATE_W-1:0]   dvs_ff, dvs_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [MS_W-1:0]     ms_ff, ms_in;
   logic [IDX_W-1:0]    bin_ff, bin_in;

   logic [RATE_W:0]     rem_sh;
   logic                qbit;
   logic [DIVD_W-1:0]   q_next;
   logic [RATE_W-1:0]   rem_next;
   logic                last_step;
   logic [PW-1:0]       bin_prod;

   always_comb begin
      rem_sh    = {rem_ff, dvd_ff[DIVD_W-1]};
      qbit      = rem_sh >= {1'b0, dvs_ff};
      rem_next  = qbit ? RATE_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[RATE_W-1:0];
      q_next    = {dvd_ff[DIVD_W-2:0], qbit};
      last_step = step_ff == STEP_W'(DIVD_W - 1);
      bin_prod  = PW'(ms_ff[XW-1:0]) * RECIP;
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      step_in  = step_ff;
      ms_in    = ms_ff;
      bin_in   = bin_ff;
      enq      = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (push) begin
               case (req_type)
                  REQ_PUT: begin
                     kind_in  = REQ_PUT;
                     dvd_in   = {{(DIVD_W-32){1'b0}}, latency_ticks} * DIVD_W'(MS_PER_SECOND);
                     rem_in   = '0;
                     dvs_in   = (rate == '0) ? RATE_W'(1) : rate;
                     step_in  = '0;
                     state_in = FR_DIV_MS;
                  end
                  REQ_CHECKPOINT: begin
                     kind_in  = REQ_CHECKPOINT;
                     state_in = FR_ENQ;
                  end
                  REQ_REPORT: begin
                     kind_in  = REQ_REPORT;
                     state_in = FR_ENQ;
                  end
                  default: begin
                     state_in = FR_IDLE;
                  end
               endcase
            end
         end
         FR_DIV_MS: begin
            dvd_in  = q_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               ms_in    = (q_next[DIVD_W-1:MS_W] != '0) ? '1 : q_next[MS_W-1:0];
               state_in = FR_DIV_BIN;
            end
         end
         FR_DIV_BIN: begin
            bin_in   = (ms_ff >= MS_W'(TOP_MS)) ? IDX_W'(BIN_COUNT - 1)
                                                : bin_prod[KS+IDX_W-1:KS];
            state_in = FR_ENQ;
         end
         FR_ENQ: begin
            if (!enq_full) begin
               enq      = 1'b1;
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      ms_ff   <= ms_in;
      bin_ff  <= bin_in;
   end

   assign busy          = state_ff != FR_IDLE;
   assign enq_item.kind = kind_ff;
   assign enq_item.ms   = ms_ff;
   assign enq_bin       = bin_ff;

endmodule

// ===== src/lhp_queue.sv =====
// Two-entry queue that decouples the front end from the histogram engine.
// Depends on lhp_pkg.
module lhp_queue #(
   parameter int IDX_W = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  lhp_pkg::item_type  wr_item,
   input  logic [IDX_W-1:0]   wr_bin,
   output logic               full,
   input  logic               rd_en,
   output logic               empty,
   output lhp_pkg::item_type  rd_item,
   output logic [IDX_W-1:0]   rd_bin
);
   import lhp_pkg::*;

   item_type          item_ff [2];
   logic [IDX_W-1:0]  bin_ff  [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_wr, do_rd;

   always_comb begin
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         item_ff[wr_ptr_ff] <= wr_item;
         bin_ff[wr_ptr_ff]  <= wr_bin;
      end
   end

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign rd_item = item_ff[rd_ptr_ff];
   assign rd_bin  = bin_ff[rd_ptr_ff];

endmodule

// ===== src/lhp_back.sv =====
// Histogram engine: bin memories, sample counting, percentile scan, folding and results.
// Clears both memories after reset. Depends on lhp_pkg.
module lhp_back #(
   parameter int BIN_COUNT    = 1024,
   parameter int BIN_WIDTH_MS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_empty,
   input  lhp_pkg::item_type                   q_item,
   input  logic [$clog2(BIN_COUNT)-1:0]        q_bin,
   output logic                                q_pop,
   output logic                                clearing,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [lhp_pkg::PCT_W-1:0]    rsp_percentile_ms,
   output logic [lhp_pkg::MS_W-1:0]            rsp_max_ms,
   output logic                                rsp_is_total
);
   import lhp_pkg::*;

   localparam int IDX_W  = $clog2(BIN_COUNT);
   localparam int CNT_W  = IDX_W + 1;
   localparam int SUM_W  = 32 + IDX_W;
   localparam int PROD_W = CNT_W + BINW_W;

   logic [31:0] int_mem [BIN_COUNT];
   logic [31:0] tot_mem [BIN_COUNT];
   logic [31:0] int_rd_ff, tot_rd_ff;

   back_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0]   line_ff, line_in;
   item_type           item_ff, item_in;
   logic [IDX_W-1:0]   bin_ff, bin_in;
   logic [MS_W-1:0]    imax_ff, imax_in;
   logic [MS_W-1:0]    omax_ff, omax_in;
   logic signed [PCT_W-1:0] pct_ff, pct_in;
   logic               rvalid_ff, rvalid_in;
   logic signed [PCT_W-1:0] rpct_ff, rpct_in;
   logic [MS_W-1:0]    rmax_ff, rmax_in;
   logic               rtot_ff, rtot_in;

   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               int_we, tot_we;
   logic [31:0]        int_wd, tot_wd;
   logic [31:0]        sel_rd;
   logic [32:0]        fold_sum;
   logic [SUM_W+3:0]   acc_x10;
   logic [PROD_W-1:0]  prod;

   always_comb begin
      sel_rd   = (item_ff.kind == REQ_REPORT) ? tot_rd_ff : int_rd_ff;
      fold_sum = {1'b0, tot_rd_ff} + {1'b0, int_rd_ff};
      acc_x10  = {acc_ff, 3'b000} + {1'b0, acc_ff, 1'b0};
      prod     = PROD_W'(line_ff) * PROD_W'(BIN_WIDTH_MS);
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      sum_in    = sum_ff;
      acc_in    = acc_ff;
      line_in   = line_ff;
      item_in   = item_ff;
      bin_in    = bin_ff;
      imax_in   = imax_ff;
      omax_in   = omax_ff;
      pct_in    = pct_ff;
      rvalid_in = rvalid_ff;
      rpct_in   = rpct_ff;
      rmax_in   = rmax_ff;
      rtot_in   = rtot_ff;
      rd_addr   = '0;
      wr_addr   = '0;
      int_we    = 1'b0;
      tot_we    = 1'b0;
      int_wd    = '0;
      tot_wd    = '0;
      q_pop     = 1'b0;
      if (rsp_pop && rvalid_ff) begin
         rvalid_in = 1'b0;
      end
      case (state_ff)
         BK_CLEAR: begin
            int_we  = 1'b1;
            tot_we  = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            if (cnt_ff == CNT_W'(BIN_COUNT - 1)) begin
               cnt_in   = '0;
               state_in = BK_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               bin_in  = q_bin;
               cnt_in  = '0;
               sum_in  = '0;
               if (q_item.kind == REQ_PUT) begin
                  state_in = BK_PUT_RD;
               end else begin
                  state_in = BK_SUM;
               end
            end
         end
         BK_PUT_RD: begin
            rd_addr  = bin_ff;
            state_in = BK_PUT_WR;
         end
         BK_PUT_WR: begin
            int_we  = 1'b1;
            wr_addr = bin_ff;
            int_wd  = (int_rd_ff == '1) ? int_rd_ff : int_rd_ff + 32'd1;
            if (item_ff.ms > imax_ff) begin
               imax_in = item_ff.ms;
            end
            state_in = BK_IDLE;
         end
         BK_SUM: begin
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(sel_rd);
            end
            if (cnt_ff != CNT_W'(BIN_COUNT)) begin
               rd_addr = cnt_ff[IDX_W-1:0];
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               cnt_in   = CNT_W'(BIN_COUNT);
               acc_in   = '0;
               line_in  = CNT_W'(BIN_COUNT);
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (cnt_ff != '0) begin
               rd_addr = IDX_W'(cnt_ff - CNT_W'(1));
               pend_in = 1'b1;
               pidx_in = rd_addr;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               if (acc_x10 > (SUM_W+4)'(sum_ff)) begin
                  state_in = BK_CALC;
               end else begin
                  acc_in  = acc_ff + SUM_W'(sel_rd);
                  line_in = CNT_W'(pidx_ff) + CNT_W'(1);
                  if (pidx_ff == '0) begin
                     state_in = BK_CALC;
                  end
               end
            end
         end
         BK_CALC: begin
            if (sum_ff == '0) begin
               pct_in = '0;
            end else if (line_ff == CNT_W'(BIN_COUNT)) begin
               pct_in = '1;
            end else if (prod > PROD_W'(PCT_MAX)) begin
               pct_in = PCT_W'(PCT_MAX);
            end else begin
               pct_in = PCT_W'(prod);
            end
            cnt_in = '0;
            if (item_ff.kind == REQ_CHECKPOINT) begin
               state_in = BK_FOLD;
            end else begin
               state_in = BK_RESULT;
            end
         end
         BK_FOLD: begin
            if (pend_ff) begin
               int_we  = 1'b1;
               tot_we  = 1'b1;
               wr_addr = pidx_ff;
               int_wd  = '0;
               tot_wd  = fold_sum[32] ? '1 : fold_sum[31:0];
            end
            if (cnt_ff != CNT_W'(BIN_COUNT)) begin
               rd_addr = cnt_ff[IDX_W-1:0];
               pend_in = 1'b1;
               pidx_in = rd_addr;
               cnt_in  = cnt_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               rpct_in   = pct_ff;
               rtot_in   = item_ff.kind == REQ_REPORT;
               if (item_ff.kind == REQ_REPORT) begin
                  rmax_in = omax_ff;
               end else begin
                  rmax_in = imax_ff;
                  omax_in = (imax_ff > omax_ff) ? imax_ff : omax_ff;
                  imax_in = '0;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_CLEAR;
         cnt_ff    <= '0;
         pend_ff   <= 1'b0;
         imax_ff   <= '0;
         omax_ff   <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pend_ff   <= pend_in;
         imax_ff   <= imax_in;
         omax_ff   <= omax_in;
         rvalid_ff <= rvalid_in;
      end
      pidx_ff <= pidx_in;
      sum_ff  <= sum_in;
      acc_ff  <= acc_in;
      line_ff <= line_in;
      item_ff <= item_in;
      bin_ff  <= bin_in;
      pct_ff  <= pct_in;
      rpct_ff <= rpct_in;
      rmax_ff <= rmax_in;
      rtot_ff <= rtot_in;
   end

   always_ff @(posedge clock) begin
      int_rd_ff <= int_mem[rd_addr];
      tot_rd_ff <= tot_mem[rd_addr];
      if (int_we) begin
         int_mem[wr_addr] <= int_wd;
      end
      if (tot_we) begin
         tot_mem[wr_addr] <= tot_wd;
      end
   end

   assign clearing          = state_ff == BK_CLEAR;
   assign rsp_empty         = !rvalid_ff;
   assign rsp_percentile_ms = rpct_ff;
   assign rsp_max_ms        = rmax_ff;
   assign rsp_is_total      = rtot_ff;

endmodule

// ===== src/latency_histogram_percentile.sv =====
// Latency histogram with 90th-percentile reporting built from lhp_front, lhp_queue, lhp_back.
// A put holds the front end through divider steps, bin lookup and hand-off (which waits while
// the queue is full), so a new request is taken only once the front end is idle; the engine
// reads and rewrites one bin per put. A checkpoint sums, scans and folds the bins, a report
// sums and scans them; the result is registered at the output once the previous one is popped.
// After reset both bin memories are cleared while req_full is high.
module latency_histogram_percentile #(
   parameter int BIN_COUNT    = 1024,
   parameter int BIN_WIDTH_MS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_type,
   input  logic [31:0]                         req_latency_ticks,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [lhp_pkg::PCT_W-1:0]    rsp_percentile_ms,
   output logic [lhp_pkg::MS_W-1:0]            rsp_max_ms,
   output logic                                rsp_is_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lhp_pkg::RATE_W-1:0]          csr_ticks_per_second
);
   import lhp_pkg::*;

   localparam int IDX_W = $clog2(BIN_COUNT);

   logic [RATE_W-1:0] rate_ff;
   logic              front_busy, clearing;
   logic              enq, q_full, q_empty, q_pop;
   item_type          enq_item, q_item;
   logic [IDX_W-1:0]  enq_bin, q_bin;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_W'(100);
      end else if (csr_valid && csr_ready) begin
         rate_ff <= csr_ticks_per_second;
      end
   end

   assign csr_ready = 1'b1;
   assign req_full  = front_busy || clearing;

   lhp_front #(
      .BIN_COUNT    (BIN_COUNT),
      .BIN_WIDTH_MS (BIN_WIDTH_MS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push && !req_full),
      .busy          (front_busy),
      .req_type      (req_type),
      .latency_ticks (req_latency_ticks),
      .rate          (rate_ff),
      .enq           (enq),
      .enq_full      (q_full),
      .enq_item      (enq_item),
      .enq_bin       (enq_bin)
   );

   lhp_queue #(
      .IDX_W (IDX_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (enq),
      .wr_item (enq_item),
      .wr_bin  (enq_bin),
      .full    (q_full),
      .rd_en   (q_pop),
      .empty   (q_empty),
      .rd_item (q_item),
      .rd_bin  (q_bin)
   );

   lhp_back #(
      .BIN_COUNT    (BIN_COUNT),
      .BIN_WIDTH_MS (BIN_WIDTH_MS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_item            (q_item),
      .q_bin             (q_bin),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_percentile_ms (rsp_percentile_ms),
      .rsp_max_ms        (rsp_max_ms),
      .rsp_is_total      (rsp_is_total)
   );

endmodule

// ===== test/latency_histogram_percentile_test.sv =====
// Self-checking testbench for the latency histogram percentile block.
// Holds its own histogram predictor, directed and random tests and a result checker.
// Depends on lhp_pkg and latency_histogram_percentile.
`timescale 1ns / 1ps

module latency_histogram_percentile_test;
   import lhp_pkg::*;

   localparam int NBINS = 1024;
   localparam int BINW = 10;
   localparam int IDLE_LIMIT = 40000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [31:0] SAT = 32'hFFFF_FFFF;

   typedef struct {
      logic signed [PCT_W-1:0] pct;
      logic [MS_W-1:0]         maxv;
      logic                    tot;
   } summary_type;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [1:0] req_type = REQ_PUT;
   logic [31:0] req_latency_ticks = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic signed [PCT_W-1:0] rsp_percentile_ms;
   logic [MS_W-1:0] rsp_max_ms;
   logic rsp_is_total;
   logic csr_valid = 0;
   logic csr_ready;
   logic [RATE_W-1:0] csr_ticks_per_second = 0;

   latency_histogram_percentile u_top (.*);

   longint unsigned interval_bins[NBINS];
   longint unsigned total_bins[NBINS];
   longint unsigned interval_max, overall_max;
   logic [RATE_W-1:0] tick_rate;
   summary_type pending_summaries[$];
   int errors = 0;
   int rsp_hold = 0;
   bit steady = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [PCT_W-1:0] boundary_of(longint unsigned h[NBINS]);
      longint unsigned total, run;
      int line;
      total = 0;
      run = 0;
      line = NBINS;
      foreach (h[i]) total += h[i];
      if (total == 0) return '0;
      for (int i = NBINS; i > 0; i--) begin
         if (run * 10 > total) break;
         run += h[i-1];
         line = i;
      end
      if (line == NBINS) return '1;
      if (line * BINW > PCT_MAX) return PCT_W'(PCT_MAX);
      return PCT_W'(line * BINW);
   endfunction

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      return (a + b > SAT) ? SAT : a + b;
   endfunction

   task automatic apply_request(logic [1:0] kind, logic [31:0] ticks);
      longint unsigned rate, ms;
      int bin;
      summary_type s;
      case (kind)
         REQ_PUT: begin
            rate = (tick_rate == 0) ? 1 : tick_rate;
            ms = longint'(ticks) * 1000 / rate;
            if (ms > SAT) ms = SAT;
            bin = (ms / BINW >= NBINS) ? NBINS - 1 : int'(ms / BINW);
            interval_bins[bin] = sat_sum(interval_bins[bin], 1);
            if (ms > interval_max) interval_max = ms;
         end
         REQ_CHECKPOINT: begin
            s.pct = boundary_of(interval_bins);
            s.maxv = MS_W'(interval_max);
            s.tot = 0;
            foreach (interval_bins[i]) begin
               total_bins[i] = sat_sum(total_bins[i], interval_bins[i]);
               interval_bins[i] = 0;
            end
            if (interval_max > overall_max) overall_max = interval_max;
            interval_max = 0;
            pending_summaries.push_back(s);
         end
         REQ_REPORT: begin
            s.pct = boundary_of(total_bins);
            s.maxv = MS_W'(overall_max);
            s.tot = 1;
            pending_summaries.push_back(s);
         end
         default: ;
      endcase
   endtask

   task automatic send_request(logic [1:0] kind, logic [31:0] ticks);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_type <= kind;
      req_latency_ticks <= ticks;
      do @(posedge clock); while (req_full);
      apply_request(kind, ticks);
   endtask

   task automatic wait_idle();
      req_push <= 0;
      wait (pending_summaries.size() == 0);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_rate(logic [RATE_W-1:0] value);
      wait_idle();
      csr_valid <= 1;
      csr_ticks_per_second <= value;
      do @(posedge clock); while (!csr_ready);
      tick_rate = value;
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] random_ticks();
      longint unsigned rate;
      rate = (tick_rate == 0) ? 1 : tick_rate;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 3);
         default: return $urandom_range(0, int'(rate * 13 / 1000 * 1000 + rate));
      endcase
   endfunction

   // Results are accepted here; each one is compared with the oldest expectation.
   initial begin
      summary_type s;
      int gap;
      wait (reset == 0);
      forever begin
         gap = steady ? 0 : $urandom_range(0, 13);
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end
         if (gap > 0) begin
            rsp_pop <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1;
         do @(posedge clock); while (rsp_empty);
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected result pct=%0d max=%0d total=%0b", $time,
                     rsp_percentile_ms, rsp_max_ms, rsp_is_total);
            errors++;
         end else begin
            s = pending_summaries.pop_front();
            if (rsp_percentile_ms !== s.pct) begin
               $display("%0t: percentile expected %0d actual %0d", $time, s.pct,
                        rsp_percentile_ms);
               errors++;
            end
            if (rsp_max_ms !== s.maxv) begin
               $display("%0t: maximum expected %0d actual %0d", $time, s.maxv, rsp_max_ms);
               errors++;
            end
            if (rsp_is_total !== s.tot) begin
               $display("%0t: total flag expected %0b actual %0b", $time, s.tot,
                        rsp_is_total);
               errors++;
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic test_empty_histograms();
      send_request(REQ_REPORT, 0);
      send_request(REQ_CHECKPOINT, 0);
      send_request(REQ_UNUSED, 32'h1234);
   endtask

   task automatic test_field_extremes();
      send_request(REQ_PUT, 0);
      send_request(REQ_PUT, 1);
      send_request(REQ_PUT, 32'hFFFF_FFFF);
      send_request(REQ_PUT, 32'h5555_5555);
      send_request(REQ_PUT, 32'hAAAA_AAAA);
      send_request(REQ_UNUSED, 32'hFFFF_FFFF);
      send_request(REQ_CHECKPOINT, 32'hFFFF_FFFF);
      send_request(REQ_REPORT, 0);
   endtask

   task automatic test_zero_rate();
      write_rate(0);
      send_request(REQ_PUT, 32'hFFFF_FFFF);
      send_request(REQ_PUT, 7);
      send_request(REQ_CHECKPOINT, 0);
      write_rate(1);
      send_request(REQ_PUT, 32'd4294967);
      send_request(REQ_PUT, 32'd4294968);
      send_request(REQ_CHECKPOINT, 0);
      write_rate(20'hFFFFF);
      send_request(REQ_PUT, 1);
      send_request(REQ_PUT, 32'hFFFF_FFFF);
      send_request(REQ_REPORT, 0);
   endtask

   task automatic test_random_phase(logic [RATE_W-1:0] rate, int count, bit no_gaps);
      int pick;
      write_rate(rate);
      steady = no_gaps;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) send_request(REQ_CHECKPOINT, $urandom());
         else if (pick < 5) send_request(REQ_REPORT, $urandom());
         else if (pick < 7) send_request(REQ_UNUSED, $urandom());
         else send_request(REQ_PUT, random_ticks());
      end
      steady = 0;
   endtask

   task automatic test_output_stall();
      wait_idle();
      rsp_hold = 6000;
      for (int n = 0; n < 4; n++) send_request(REQ_REPORT, 0);
      for (int n = 0; n < 20; n++) send_request(REQ_PUT, random_ticks());
      send_request(REQ_CHECKPOINT, 0);
   endtask

   initial begin
      tick_rate = 100;
      interval_max = 0;
      overall_max = 0;
      foreach (interval_bins[i]) begin
         interval_bins[i] = 0;
         total_bins[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      test_empty_histograms();
      test_field_extremes();
      test_zero_rate();
      test_random_phase(100, 260, 0);
      test_random_phase(1, 260, 1);
      test_random_phase(20'hFFFFF, 260, 0);
      test_random_phase(20'(1000000), 260, 0);
      test_random_phase(20'($urandom_range(2, 5000)), 260, 0);
      test_output_stall();
      wait_idle();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
